FILE: design/srfd_pkg.sv
// Shared types, constants and helper functions for the sensor response frame decoder.
`default_nettype none

package srfd_pkg;

	typedef enum logic [1:0] {
		KIND_FORCE    = 2'd0,
		KIND_ANGLE    = 2'd1,
		KIND_DISTANCE = 2'd2,
		KIND_BATTERY  = 2'd3
	} kind_t;

	// Frame layout positions.
	localparam logic [7:0] PAYLOAD_FIRST = 8'd3;
	localparam logic [7:0] PAYLOAD_LAST  = 8'd6;
	localparam logic [7:0] FIELD_FIRST   = 8'd93;
	localparam logic [7:0] FIELD_LAST    = 8'd104;
	localparam logic [7:0] BATT_HEAD     = 8'h7E;
	localparam logic [7:0] BATT_TAIL     = 8'h0D;
	localparam logic [7:0] ADDR_MIN      = 8'd1;
	localparam logic [7:0] ADDR_MAX      = 8'd4;

	// Angle scale: raw word times 180 gives q15 degrees.
	localparam logic [8:0] ANGLE_SCALE = 9'd180;

	// floor(f / 1000) = floor(((f >> 3) * DIV1000_MUL) >> DIV1000_SHIFT) for 16-bit f.
	localparam logic [13:0] DIV1000_MUL   = 14'd8389;
	localparam int          DIV1000_SHIFT = 20;

	// floor(f * 65536 / 36000) = floor((f * CHARGE_MUL) >> CHARGE_SHIFT) for 16-bit f.
	localparam logic [27:0] CHARGE_MUL   = 28'd244335918;
	localparam int          CHARGE_SHIFT = 27;

	typedef struct packed {
		logic       en;
		logic [7:0] pos;
		logic [7:0] data;
	} capture_t;

	typedef struct packed {
		logic [6:0]  current;
		logic [6:0]  voltage;
		logic [16:0] charge;
		logic        error;
	} batt_result_t;

	// Position of the last byte of a frame for each sensor type.
	function automatic logic [7:0] frame_last(input kind_t kind);
		logic [7:0] last;
		case (kind)
			KIND_FORCE:    last = 8'd8;
			KIND_ANGLE:    last = 8'd10;
			KIND_DISTANCE: last = 8'd6;
			KIND_BATTERY:  last = 8'd135;
			default:       last = 8'd8;
		endcase
		return last;
	endfunction

	function automatic logic signed [32:0] station_offset(input logic [1:0] station);
		logic signed [32:0] offset;
		case (station)
			2'd0:    offset = 33'sd440;
			2'd1:    offset = -33'sd375;
			2'd2:    offset = 33'sd500;
			2'd3:    offset = 33'sd3300;
			default: offset = 33'sd0;
		endcase
		return offset;
	endfunction

	// Returns {valid, nibble}; an invalid character gives a zero nibble.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end else begin
			r = 5'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/srfd_batt_fields.sv
// Battery ASCII-hex field capture and the scaled current, voltage and charge values.
`default_nettype none

module srfd_batt_fields (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire srfd_pkg::capture_t     cap,
	output srfd_pkg::batt_result_t      res
);

	logic [15:0] fields_q [3];
	logic [2:0]  bad_q;
	srfd_pkg::batt_result_t res_q;

	logic [7:0]  off;
	logic [1:0]  idx;
	logic        in_range;
	logic        first;
	logic [4:0]  hex;
	logic [15:0] fv0, fv1, fv2;
	logic [26:0] prod0, prod1;
	logic [43:0] prod2;

	always_comb begin
		off      = cap.pos - srfd_pkg::FIELD_FIRST;
		idx      = off[3:2];
		first    = (off[1:0] == 2'd0);
		in_range = cap.en && (cap.pos >= srfd_pkg::FIELD_FIRST) &&
			(cap.pos <= srfd_pkg::FIELD_LAST);
		hex      = srfd_pkg::hex_nibble(cap.data);
	end

	always_ff @(posedge clk) begin
		if (in_range) begin
			if (first) begin
				fields_q[idx] <= {12'd0, hex[3:0]};
			end else begin
				fields_q[idx] <= {fields_q[idx][11:0], hex[3:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 3'b000;
		end else if (in_range) begin
			if (first) begin
				bad_q[idx] <= !hex[4];
			end else if (!hex[4]) begin
				bad_q[idx] <= 1'b1;
			end
		end
	end

	// A field holding a bad character decodes as zero.
	always_comb begin
		fv0   = bad_q[0] ? 16'd0 : fields_q[0];
		fv1   = bad_q[1] ? 16'd0 : fields_q[1];
		fv2   = bad_q[2] ? 16'd0 : fields_q[2];
		prod0 = 27'(fv0[15:3]) * 27'(srfd_pkg::DIV1000_MUL);
		prod1 = 27'(fv1[15:3]) * 27'(srfd_pkg::DIV1000_MUL);
		prod2 = 44'(fv2) * 44'(srfd_pkg::CHARGE_MUL);
	end

	always_ff @(posedge clk) begin
		res_q.current <= prod0[srfd_pkg::DIV1000_SHIFT +: 7];
		res_q.voltage <= prod1[srfd_pkg::DIV1000_SHIFT +: 7];
		res_q.charge  <= prod2[srfd_pkg::CHARGE_SHIFT +: 17];
		res_q.error   <= |bad_q;
	end

	assign res = res_q;

endmodule

`default_nettype wire

FILE: design/sensor_response_frame_decoder_unit.sv
// Top level of the sensor response frame decoder: framing, decode and result register.
`default_nettype none

// Received serial bytes arrive on the input channel (in_valid, in_stall, rx_byte); each
// transaction moves one byte. Bytes are counted into fixed-length frames whose length is
// set by the sensor type register (force 9, angle 11, distance 7, battery 136 bytes).
// Frames are counted from reset with no resynchronisation, and the response CRC is not
// checked. When a frame completes and passes its address or framing checks (angle frames have
// none), one result transaction is offered on the output channel (out_valid, out_stall and the
// result fields); a rejected frame simply produces nothing.
// The input byte is captured in an input register and the frame state and the decoded
// result are updated from it into the result register. One byte is accepted in every
// cycle while the receiver does not stall; the rate is set by the single decode pass
// between the input register and the result register.
// The battery current, voltage and charge quotients are computed in a register of their
// own from the stored ASCII-hex fields, which are complete long before the frame ends.
// When the receiver stalls, the result register holds its transaction, the input register
// fills and in_stall is raised until the result is taken.
// Reset clears the byte position, the head byte, the sensor type (force) and the bad
// character flags, and empties both pipeline stages. The sensor type register is written
// through cfg_wr_en and cfg_wr_data and must only be changed while the block is idle.

module sensor_response_frame_decoder_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              result_kind,
	output logic [1:0]              station,
	output logic signed [32:0]      force_value,
	output logic signed [23:0]      angle_x,
	output logic signed [23:0]      angle_y,
	output logic [15:0]             distance,
	output logic [6:0]              pack_current,
	output logic [6:0]              pack_voltage,
	output logic [16:0]             remaining_charge,
	output logic                    ascii_error
);

	srfd_pkg::kind_t sensor_type_q;
	logic [7:0]      byte_pos_q;
	logic [7:0]      head_byte_q;
	logic [7:0]      payload_q [4];

	// Input register.
	logic            valid_s1;
	logic [7:0]      byte_s1;

	// Result register.
	logic            out_valid_q;
	logic [1:0]      kind_q;
	logic [1:0]      station_q;
	logic [32:0]     force_q;
	logic [23:0]     angle_x_q;
	logic [23:0]     angle_y_q;
	logic [15:0]     distance_q;
	logic [6:0]      current_q;
	logic [6:0]      voltage_q;
	logic [16:0]     charge_q;
	logic            error_q;

	logic            out_ready;
	logic            fire_s1;
	logic            frame_done;
	logic            payload_hit;
	logic [1:0]      payload_idx;
	logic [7:0]      payload_nx [4];
	logic [7:0]      head_nx;
	logic            addr_ok;
	logic [1:0]      station_nx;
	logic [31:0]     force_raw;
	logic signed [32:0] force_nx;
	logic [15:0]     word_x, word_y;
	logic signed [24:0] angle_x_full, angle_y_full;
	logic            produce;

	srfd_pkg::capture_t     cap;
	srfd_pkg::batt_result_t batt;

	// The byte in the input register moves on whenever the result register can take it.
	assign out_ready = !out_valid_q || !out_stall;
	assign fire_s1   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= srfd_pkg::KIND_FORCE;
		end else if (cfg_wr_en) begin
			sensor_type_q <= srfd_pkg::kind_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state after this byte has been taken in; the decode works on these values.
	always_comb begin
		frame_done  = (byte_pos_q >= srfd_pkg::frame_last(sensor_type_q));
		payload_hit = (sensor_type_q != srfd_pkg::KIND_BATTERY) &&
			(byte_pos_q >= srfd_pkg::PAYLOAD_FIRST) && (byte_pos_q <= srfd_pkg::PAYLOAD_LAST);
		payload_idx = 2'(byte_pos_q - srfd_pkg::PAYLOAD_FIRST);
		for (int i = 0; i < 4; i++) begin
			payload_nx[i] = payload_q[i];
		end
		if (payload_hit) begin
			payload_nx[payload_idx] = byte_s1;
		end
		head_nx    = (byte_pos_q == 8'd0) ? byte_s1 : head_byte_q;
		addr_ok    = (head_nx >= srfd_pkg::ADDR_MIN) && (head_nx <= srfd_pkg::ADDR_MAX);
		station_nx = head_nx[1:0] - 2'd1;

		// Force reading arrives with its two 16-bit words swapped.
		force_raw = {payload_nx[2], payload_nx[3], payload_nx[0], payload_nx[1]};
		force_nx  = $signed({force_raw[31], force_raw}) + srfd_pkg::station_offset(station_nx);

		word_x = {payload_nx[0], payload_nx[1]};
		word_y = {payload_nx[2], payload_nx[3]};
		angle_x_full = $signed({{9{word_x[15]}}, word_x}) *
			$signed(25'(srfd_pkg::ANGLE_SCALE));
		angle_y_full = $signed({{9{word_y[15]}}, word_y}) *
			$signed(25'(srfd_pkg::ANGLE_SCALE));

		case (sensor_type_q)
			srfd_pkg::KIND_FORCE:    produce = addr_ok;
			srfd_pkg::KIND_ANGLE:    produce = 1'b1;
			srfd_pkg::KIND_DISTANCE: produce = addr_ok;
			srfd_pkg::KIND_BATTERY:  produce = (head_nx == srfd_pkg::BATT_HEAD) &&
				(byte_s1 == srfd_pkg::BATT_TAIL);
			default:                 produce = 1'b0;
		endcase
		produce = produce && frame_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= 8'd0;
			head_byte_q <= 8'd0;
		end else if (fire_s1) begin
			byte_pos_q  <= frame_done ? 8'd0 : byte_pos_q + 8'd1;
			head_byte_q <= head_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && payload_hit) begin
			payload_q[payload_idx] <= byte_s1;
		end
	end

	assign cap.en   = fire_s1 && (sensor_type_q == srfd_pkg::KIND_BATTERY);
	assign cap.pos  = byte_pos_q;
	assign cap.data = byte_s1;

	srfd_batt_fields u_batt (
		.clk    (clk),
		.arst_n (arst_n),
		.cap    (cap),
		.res    (batt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= fire_s1 && produce;
		end
	end

	// Fields that do not belong to the frame's sensor type read as zero.
	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			kind_q     <= sensor_type_q;
			station_q  <= 2'd0;
			force_q    <= 33'd0;
			angle_x_q  <= 24'd0;
			angle_y_q  <= 24'd0;
			distance_q <= 16'd0;
			current_q  <= 7'd0;
			voltage_q  <= 7'd0;
			charge_q   <= 17'd0;
			error_q    <= 1'b0;
			case (sensor_type_q)
				srfd_pkg::KIND_FORCE: begin
					station_q <= station_nx;
					force_q   <= force_nx;
				end
				srfd_pkg::KIND_ANGLE: begin
					angle_x_q <= angle_x_full[23:0];
					angle_y_q <= angle_y_full[23:0];
				end
				srfd_pkg::KIND_DISTANCE: begin
					station_q  <= station_nx;
					distance_q <= word_x;
				end
				srfd_pkg::KIND_BATTERY: begin
					current_q <= batt.current;
					voltage_q <= batt.voltage;
					charge_q  <= batt.charge;
					error_q   <= batt.error;
				end
				default: begin
					station_q <= 2'd0;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign station          = station_q;
	assign force_value      = $signed(force_q);
	assign angle_x          = $signed(angle_x_q);
	assign angle_y          = $signed(angle_y_q);
	assign distance         = distance_q;
	assign pack_current     = current_q;
	assign pack_voltage     = voltage_q;
	assign remaining_charge = charge_q;
	assign ascii_error      = error_q;

endmodule

`default_nettype wire
